// ----- hw/rtl/frontier_cell_classifier_defines.svh -----
// Assertion helpers shared by the frontier cell classifier sources.
`ifndef FRONTIER_CELL_CLASSIFIER_DEFINES_SVH
`define FRONTIER_CELL_CLASSIFIER_DEFINES_SVH

// A property checked on every rising clock edge outside reset.
`define FCC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// An implication whose consequent is checked in the cycle after its antecedent.
`define FCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/fcc_pkg.sv -----
package fcc_pkg;

  // Store geometry.
  localparam int MAX_ROWS = 256;
  localparam int MAX_COLS = 256;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ADDR_W   = ROW_W + COL_W;
  localparam int CELLS    = 2 ** ADDR_W;

  // Width of the fixed item coordinate fields.
  localparam int CRD_IN_W = 8;

  // Signed working width for window coordinates and map limits.
  localparam int CRD_BASE = (ROW_W > COL_W) ? ROW_W : COL_W;
  localparam int CRD_W    = ((CRD_BASE > CRD_IN_W) ? CRD_BASE : CRD_IN_W) + 2;

  // The 5x5 window around the classified cell.
  localparam int WIN       = 5;
  localparam int WIN_HALF  = WIN / 2;
  localparam int WIN_N     = WIN * WIN;
  localparam int WIN_CRD_W = $clog2(WIN);
  localparam int WIN_IDX_W = $clog2(WIN_N);
  localparam int CENTRE    = WIN_HALF * WIN + WIN_HALF;

  // Configuration port.
  localparam int REG_IDX_W = 3;
  localparam int PADDR_W   = REG_IDX_W + 2;
  localparam int PDATA_W   = 32;

  typedef enum logic {
    CMD_WRITE    = 1'b0,
    CMD_CLASSIFY = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_FRONTIER = 2'd1,
    KIND_OCCUPIED = 2'd2
  } kind_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MAP_ROWS    = 3'd0,
    REG_MAP_COLS    = 3'd1,
    REG_FREE        = 3'd2,
    REG_UNKNOWN     = 3'd3,
    REG_OCCUPIED    = 3'd4,
    REG_INFLATED    = 3'd5,
    REG_MIN_UNKNOWN = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_EVAL
  } state_e;

  typedef struct packed {
    cmd_e                        cmd;
    logic [CRD_IN_W-1:0]         cell_row;
    logic [CRD_IN_W-1:0]         cell_col;
    logic signed [7:0]           occupancy_in;
    logic signed [7:0]           cost_in;
  } fcc_item_t;

  typedef struct packed {
    kind_e                       cell_kind;
    logic [CRD_IN_W-1:0]         out_row;
    logic [CRD_IN_W-1:0]         out_col;
  } fcc_result_t;

  typedef struct packed {
    logic [8:0]                  map_rows;
    logic [8:0]                  map_cols;
    logic signed [7:0]           free_value;
    logic signed [7:0]           unknown_value;
    logic signed [7:0]           occupied_value;
    logic signed [7:0]           inflated_value;
    logic [3:0]                  min_unknown_neighbors;
  } fcc_cfg_t;

  // One memory word holds both bytes of a cell.
  typedef struct packed {
    logic signed [7:0]           occ;
    logic signed [7:0]           cost;
  } fcc_cell_t;

  localparam int CELL_W = $bits(fcc_cell_t);

endpackage

// ----- hw/rtl/frontier_cell_classifier.sv -----
// A write item (start high while busy is low) stores one cell's occupancy
// and cost bytes and raises no busy and no result. A classify item holds
// busy while the 25 cells of the 5x5 window around the cell are read one
// per cycle through the single port of the cell memory, in the drain
// state for the memory's read latency and in the evaluation state. The
// result strobe valid_o rises as busy falls and stays high for one cycle
// only; the receiver must take result_o then, as the block cannot be held
// off. A new item may be started in that same cycle. Configuration is to
// be written over the APB port only while no item is in flight; the block
// does not enforce it. The cell memory is not cleared after reset: every
// cell is to be written before a classify reads it.
`include "frontier_cell_classifier_defines.svh"

module frontier_cell_classifier (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  fcc_pkg::fcc_item_t          item_i,
  output logic                        valid_o,
  output fcc_pkg::fcc_result_t        result_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fcc_pkg::PADDR_W-1:0] paddr,
  input  logic [fcc_pkg::PDATA_W-1:0] pwdata,
  output logic [fcc_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import fcc_pkg::*;

  fcc_cfg_t               cfg;
  state_e                 state_d, state_q;
  logic                   accept;

  logic [CRD_IN_W-1:0]    row_q, col_q;
  logic [WIN_CRD_W-1:0]   wr_d, wr_q, wc_d, wc_q;
  logic [WIN_IDX_W-1:0]   idx_d, idx_q;
  logic                   rd_vld_d, rd_vld_q;
  logic [WIN_IDX_W-1:0]   rd_idx_q;
  logic [WIN_N-1:0]       unk_q;
  logic                   ctr_in_q;
  fcc_cell_t              ctr_q;
  logic                   valid_d, valid_q;
  fcc_result_t            result_q;
  kind_e                  kind;

  logic [CRD_W-1:0]        rows_lim, cols_lim;
  logic signed [CRD_W-1:0] rr, cc;
  logic                    win_vld, wr_ok, ram_we;
  logic [ADDR_W-1:0]       ram_addr, wr_addr, sweep_addr;
  fcc_cell_t               ram_wdata, ram_rdata;

  // Configuration registers.
  fcc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // Map limits clipped to the store size.
  assign rows_lim = (CRD_W'(cfg.map_rows) > CRD_W'(MAX_ROWS)) ?
                    CRD_W'(MAX_ROWS) : CRD_W'(cfg.map_rows);
  assign cols_lim = (CRD_W'(cfg.map_cols) > CRD_W'(MAX_COLS)) ?
                    CRD_W'(MAX_COLS) : CRD_W'(cfg.map_cols);

  // Coordinates of the current window position and whether it lies in the map.
  assign rr = $signed(CRD_W'(row_q)) + $signed(CRD_W'(wr_q)) - $signed(CRD_W'(WIN_HALF));
  assign cc = $signed(CRD_W'(col_q)) + $signed(CRD_W'(wc_q)) - $signed(CRD_W'(WIN_HALF));
  assign win_vld = (rr >= 0) && (rr < $signed(rows_lim)) &&
                   (cc >= 0) && (cc < $signed(cols_lim));
  assign sweep_addr = {rr[ROW_W-1:0], cc[COL_W-1:0]};

  // Write items go straight to the memory; cells beyond the store are dropped.
  assign wr_ok   = (CRD_W'(item_i.cell_row) < CRD_W'(MAX_ROWS)) &&
                   (CRD_W'(item_i.cell_col) < CRD_W'(MAX_COLS));
  assign wr_addr = {ROW_W'(item_i.cell_row), COL_W'(item_i.cell_col)};
  assign ram_we  = accept && (item_i.cmd == CMD_WRITE) && wr_ok;
  assign ram_addr  = (state_q == ST_IDLE) ? wr_addr : sweep_addr;
  assign ram_wdata = '{occ: item_i.occupancy_in, cost: item_i.cost_in};

  // Both grids share one memory word per cell.
  fcc_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Sequencer: sweep the window, let the last read land, then evaluate.
  always_comb begin
    state_d  = state_q;
    wr_d     = wr_q;
    wc_d     = wc_q;
    idx_d    = idx_q;
    rd_vld_d = 1'b0;
    valid_d  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        wr_d  = '0;
        wc_d  = '0;
        idx_d = '0;
        if (accept && item_i.cmd == CMD_CLASSIFY) begin
          state_d = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        rd_vld_d = win_vld;
        idx_d    = idx_q + 1'b1;
        if (wc_q == WIN_CRD_W'(WIN - 1)) begin
          wc_d = '0;
          wr_d = wr_q + 1'b1;
        end else begin
          wc_d = wc_q + 1'b1;
        end
        if (idx_q == WIN_IDX_W'(WIN_N - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        valid_d = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rd_vld_q <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_vld_d;
      valid_q  <= valid_d;
    end
  end

  // Window position counters and the item's coordinates.
  always_ff @(posedge clk_i) begin
    wr_q     <= wr_d;
    wc_q     <= wc_d;
    idx_q    <= idx_d;
    rd_idx_q <= idx_q;
    if (accept) begin
      row_q <= item_i.cell_row;
      col_q <= item_i.cell_col;
    end
  end

  // Collect the unknown marks of the window and the centre cell's bytes.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      unk_q    <= '0;
      ctr_in_q <= 1'b0;
    end else if (rd_vld_q) begin
      unk_q[rd_idx_q] <= (ram_rdata.occ == cfg.unknown_value);
      if (rd_idx_q == WIN_IDX_W'(CENTRE)) begin
        ctr_in_q <= 1'b1;
        ctr_q    <= ram_rdata;
      end
    end
  end

  fcc_eval u_eval (
    .cfg_i    (cfg),
    .unk_i    (unk_q),
    .ctr_in_i (ctr_in_q),
    .ctr_i    (ctr_q),
    .kind_o   (kind)
  );

  // Result register, loaded in the evaluation state and marked valid for one cycle.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EVAL) begin
      result_q <= '{cell_kind: kind, out_row: row_q, out_col: col_q};
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

  `FCC_ASSERT(a_valid_after_eval, valid_o |-> $past(state_q == ST_EVAL), "result without evaluation")
  `FCC_ASSERT(a_valid_idle, valid_o |-> !busy, "result shown while busy")
  `FCC_ASSERT_NEXT(a_valid_single, valid_o, !valid_o, "result strobe longer than one cycle")
  `FCC_ASSERT(a_read_in_sweep, rd_vld_q |-> $past(state_q == ST_SWEEP), "window read outside sweep")
  `FCC_ASSERT(a_write_idle, ram_we |-> (state_q == ST_IDLE), "cell write during a classify")

endmodule

// ----- hw/rtl/fcc_ram.sv -----
module fcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single port: a registered read each cycle, with an optional write to the same address.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/fcc_cfg.sv -----
module fcc_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fcc_pkg::PADDR_W-1:0] paddr,
  input  logic [fcc_pkg::PDATA_W-1:0] pwdata,
  output logic [fcc_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output fcc_pkg::fcc_cfg_t           cfg_o
);
  import fcc_pkg::*;

  fcc_cfg_t               cfg_d, cfg_q;
  logic                   wr_en;
  logic [REG_IDX_W-1:0]   reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[PADDR_W-1:2];

  // Register write decode; addresses beyond the list are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_MAP_ROWS:    cfg_d.map_rows              = pwdata[8:0];
        REG_MAP_COLS:    cfg_d.map_cols              = pwdata[8:0];
        REG_FREE:        cfg_d.free_value            = pwdata[7:0];
        REG_UNKNOWN:     cfg_d.unknown_value         = pwdata[7:0];
        REG_OCCUPIED:    cfg_d.occupied_value        = pwdata[7:0];
        REG_INFLATED:    cfg_d.inflated_value        = pwdata[7:0];
        REG_MIN_UNKNOWN: cfg_d.min_unknown_neighbors = pwdata[3:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.map_rows              <= 9'd256;
      cfg_q.map_cols              <= 9'd256;
      cfg_q.free_value            <= 8'sd0;
      cfg_q.unknown_value         <= -8'sd1;
      cfg_q.occupied_value        <= 8'sd100;
      cfg_q.inflated_value        <= 8'sd99;
      cfg_q.min_unknown_neighbors <= 4'd2;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read data, zero extended to the bus width.
  always_comb begin
    case (reg_idx)
      REG_MAP_ROWS:    prdata = PDATA_W'(cfg_q.map_rows);
      REG_MAP_COLS:    prdata = PDATA_W'(cfg_q.map_cols);
      REG_FREE:        prdata = PDATA_W'(unsigned'(cfg_q.free_value));
      REG_UNKNOWN:     prdata = PDATA_W'(unsigned'(cfg_q.unknown_value));
      REG_OCCUPIED:    prdata = PDATA_W'(unsigned'(cfg_q.occupied_value));
      REG_INFLATED:    prdata = PDATA_W'(unsigned'(cfg_q.inflated_value));
      REG_MIN_UNKNOWN: prdata = PDATA_W'(cfg_q.min_unknown_neighbors);
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/fcc_eval.sv -----
module fcc_eval (
  input  fcc_pkg::fcc_cfg_t             cfg_i,
  input  logic [fcc_pkg::WIN_N-1:0]     unk_i,
  input  logic                          ctr_in_i,
  input  fcc_pkg::fcc_cell_t            ctr_i,
  output fcc_pkg::kind_e                kind_o
);
  import fcc_pkg::*;

  logic hit;

  // An unknown 8-neighbour confirms the frontier when enough of its own
  // 8-neighbours are unknown. Window bits outside the map are already clear.
  always_comb begin
    logic [3:0] cnt;
    hit = 1'b0;
    for (int a = 1; a <= WIN - 2; a++) begin
      for (int b = 1; b <= WIN - 2; b++) begin
        cnt = '0;
        for (int da = -1; da <= 1; da++) begin
          for (int db = -1; db <= 1; db++) begin
            if (da != 0 || db != 0) begin
              cnt = cnt + 4'(unk_i[(a + da) * WIN + (b + db)]);
            end
          end
        end
        if ((a != WIN_HALF || b != WIN_HALF) && unk_i[a * WIN + b] &&
            (cnt >= cfg_i.min_unknown_neighbors)) begin
          hit = 1'b1;
        end
      end
    end
  end

  // Final kind of the centre cell; a free cell never reports occupied.
  always_comb begin
    if (!ctr_in_i) begin
      kind_o = KIND_NONE;
    end else if (ctr_i.occ == cfg_i.free_value) begin
      kind_o = (ctr_i.cost != cfg_i.inflated_value && hit) ? KIND_FRONTIER : KIND_NONE;
    end else begin
      kind_o = (ctr_i.cost == cfg_i.occupied_value) ? KIND_OCCUPIED : KIND_NONE;
    end
  end

endmodule
